/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files of the option pricing unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BLOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define BLOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BLOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BLOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/blop_pkg.sv */
// Types and constants shared by the binomial lattice option pricing unit.
package blop_pkg;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  typedef enum logic [2:0] {
    CFG_UP_FACTOR       = 3'd0,
    CFG_DOWN_FACTOR     = 3'd1,
    CFG_PROB_UP         = 3'd2,
    CFG_DISCOUNT_FACTOR = 3'd3,
    CFG_STEP_COUNT      = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    MUL_Q30,
    MUL_Q31,
    MUL_MIX
  } mul_op_t;

  typedef struct packed {
    logic        issue;
    mul_op_t     op;
    logic [32:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        sat;
  } mul_rsp_t;

  typedef struct packed {
    logic [31:0] spot_price;
    logic [31:0] strike;
    logic        is_call;
  } in_word_t;

  typedef struct packed {
    logic [31:0] option_price;
    logic        saturated;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_W,
    S_PAY,
    S_DN1_W,
    S_DN2_W,
    S_LVL,
    S_RD0,
    S_MIX,
    S_MIX_W,
    S_DISC_W,
    S_RDB,
    S_FIN
  } state_t;

endpackage

/* rtl/core/binomial_lattice_option_price_unit.sv */
// Top level of the binomial lattice option pricing unit.
//
// Prices one European call or put per input word on a binomial lattice.
// Software must write the up and down factors, the up probability, the per-step
// discount and the step count n through the cfg_ port only while the unit is
// idle; the unit does not enforce this. The input word carries spot, strike
// and the call flag; the result word carries the root value and a flag set if
// any node price, blended or discounted value saturated at the Q16.16 maximum.
// One shared two-stage multiplier does every product under a small sequencer,
// and the node values live in a RAM of MAX_STEPS+1 words with one read and
// one write port. An item first runs the up moves, then writes each terminal
// node's payoff, then folds the lattice level by level, each level starting
// with its reads; in_stall is high from acceptance until the result word is
// handed to the output register.
// The result sits in an output register, so a new word is accepted once the
// sequencer has handed its result over, even while out_stall holds it; if the
// register is still full and stalled when the next result is ready, the sequencer waits.
// Synchronous reset restores the configuration defaults and empties the
// output register.
module binomial_lattice_option_price_unit #(
  parameter int MAX_STEPS = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  blop_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output blop_pkg::out_word_t out_data
);

`include "assert_macros.svh"

  localparam int NW = $clog2(MAX_STEPS + 1);

  // Configuration registers.
  logic [31:0] up_r;
  logic [30:0] down_r;
  logic [31:0] prob_r;
  logic [31:0] disc_r;
  logic [7:0]  steps_r;

  // Sequencer and per-item working registers.
  blop_pkg::state_t state_r, state_nxt;
  logic [31:0]   price_r, price_nxt;
  logic [31:0]   strike_r, strike_nxt;
  logic          call_r, call_nxt;
  logic [31:0]   p_r, p_nxt;
  logic [31:0]   a_r, a_nxt;
  logic [31:0]   root_r, root_nxt;
  logic          sat_r, sat_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] i_r, i_nxt;
  logic [NW-1:0] j_r, j_nxt;
  logic                out_valid_r, out_valid_nxt;
  blop_pkg::out_word_t out_data_r, out_data_nxt;

  logic [31:0]   n_wide;
  logic [NW-1:0] n_clamp;
  logic [31:0]   p_clamp;
  logic [NW-1:0] i_inc;
  logic          last_in_level;
  logic [32:0]   mix_diff;
  logic          accept;
  logic          fin_go;
  logic          mul_wait;

  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [NW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  blop_pkg::mul_req_t mul_req;
  blop_pkg::mul_rsp_t mul_rsp;

  function automatic logic [31:0] payoff(input logic [31:0] price,
                                         input logic [31:0] k,
                                         input logic        call);
    logic [31:0] r;
    r = '0;
    if (call) begin
      if (price > k) r = price - k;
    end else if (k > price) begin
      r = k - price;
    end
    return r;
  endfunction

  // A step count of zero means one step; counts beyond the RAM are capped.
  always_comb begin
    n_wide = {24'b0, steps_r};
    if (steps_r == 8'd0) n_wide = 32'd1;
    if (n_wide > 32'(MAX_STEPS)) n_wide = 32'(MAX_STEPS);
  end
  assign n_clamp = n_wide[NW-1:0];

  // A probability above one is taken as exactly one.
  assign p_clamp = (prob_r > blop_pkg::ONE_Q31) ? blop_pkg::ONE_Q31 : prob_r;

  assign i_inc         = i_r + NW'(1);
  assign last_in_level = (i_inc == j_r);
  // p*V[i] + (1-p)*V[i+1] is formed as V[i+1]*2^31 + p*(V[i] - V[i+1]).
  assign mix_diff      = {1'b0, a_r} - {1'b0, ram_rdata};
  assign accept        = in_valid && !in_stall;
  assign fin_go        = (state_r == blop_pkg::S_FIN) && (!out_valid_r || !out_stall);
  assign mul_wait      = (state_r == blop_pkg::S_UP_W) || (state_r == blop_pkg::S_DN1_W) ||
                         (state_r == blop_pkg::S_DN2_W) || (state_r == blop_pkg::S_MIX_W) ||
                         (state_r == blop_pkg::S_DISC_W);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r    <= 32'h4000_0000;
      down_r  <= 31'h4000_0000;
      prob_r  <= 32'h4000_0000;
      disc_r  <= 32'h8000_0000;
      steps_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        blop_pkg::CFG_UP_FACTOR:       up_r    <= cfg_data;
        blop_pkg::CFG_DOWN_FACTOR:     down_r  <= cfg_data[30:0];
        blop_pkg::CFG_PROB_UP:         prob_r  <= cfg_data;
        blop_pkg::CFG_DISCOUNT_FACTOR: disc_r  <= cfg_data;
        blop_pkg::CFG_STEP_COUNT:      steps_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Next state. Each multiplier wait state leaves on the unit's done pulse.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blop_pkg::S_IDLE:   if (in_valid) state_nxt = blop_pkg::S_UP;
      blop_pkg::S_UP:     state_nxt = (cnt_r == n_r) ? blop_pkg::S_PAY : blop_pkg::S_UP_W;
      blop_pkg::S_UP_W:   if (mul_rsp.done) state_nxt = blop_pkg::S_UP;
      blop_pkg::S_PAY:    state_nxt = (idx_r == n_r) ? blop_pkg::S_LVL : blop_pkg::S_DN1_W;
      blop_pkg::S_DN1_W:  if (mul_rsp.done) state_nxt = blop_pkg::S_DN2_W;
      blop_pkg::S_DN2_W:  if (mul_rsp.done) state_nxt = blop_pkg::S_PAY;
      blop_pkg::S_LVL:    state_nxt = blop_pkg::S_RD0;
      blop_pkg::S_RD0:    state_nxt = blop_pkg::S_MIX;
      blop_pkg::S_MIX:    state_nxt = blop_pkg::S_MIX_W;
      blop_pkg::S_MIX_W:  if (mul_rsp.done) state_nxt = blop_pkg::S_DISC_W;
      blop_pkg::S_DISC_W: begin
        if (mul_rsp.done) begin
          if (!last_in_level) begin
            state_nxt = blop_pkg::S_RDB;
          end else if (j_r == NW'(1)) begin
            state_nxt = blop_pkg::S_FIN;
          end else begin
            state_nxt = blop_pkg::S_LVL;
          end
        end
      end
      blop_pkg::S_RDB:    state_nxt = blop_pkg::S_MIX;
      blop_pkg::S_FIN:    if (fin_go) state_nxt = blop_pkg::S_IDLE;
      default:            state_nxt = blop_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier requests, RAM controls and input stall.
  always_comb begin
    in_stall  = (state_r != blop_pkg::S_IDLE);
    mul_req   = '0;
    ram_we    = 1'b0;
    ram_waddr = i_r;
    ram_wdata = mul_rsp.value;
    ram_raddr = i_inc;
    case (state_r)
      blop_pkg::S_UP: begin
        mul_req.issue = (cnt_r != n_r);
        mul_req.op    = blop_pkg::MUL_Q30;
        mul_req.a     = {1'b0, price_r};
        mul_req.b     = up_r;
      end
      blop_pkg::S_PAY: begin
        ram_we        = 1'b1;
        ram_waddr     = idx_r;
        ram_wdata     = payoff(price_r, strike_r, call_r);
        mul_req.issue = (idx_r != n_r);
        mul_req.op    = blop_pkg::MUL_Q30;
        mul_req.a     = {1'b0, price_r};
        mul_req.b     = {1'b0, down_r};
      end
      blop_pkg::S_DN1_W: begin
        // Second down move chains straight off the first result.
        mul_req.issue = mul_rsp.done;
        mul_req.op    = blop_pkg::MUL_Q30;
        mul_req.a     = {1'b0, mul_rsp.value};
        mul_req.b     = {1'b0, down_r};
      end
      blop_pkg::S_LVL: begin
        ram_raddr = '0;
      end
      blop_pkg::S_MIX: begin
        mul_req.issue = 1'b1;
        mul_req.op    = blop_pkg::MUL_MIX;
        mul_req.a     = mix_diff;
        mul_req.b     = p_r;
        mul_req.c     = ram_rdata;
      end
      blop_pkg::S_MIX_W: begin
        mul_req.issue = mul_rsp.done;
        mul_req.op    = blop_pkg::MUL_Q31;
        mul_req.a     = {1'b0, mul_rsp.value};
        mul_req.b     = disc_r;
      end
      blop_pkg::S_DISC_W: begin
        ram_we = mul_rsp.done;
      end
      default: begin
      end
    endcase
  end

  // Working registers.
  always_comb begin
    price_nxt  = price_r;
    strike_nxt = strike_r;
    call_nxt   = call_r;
    p_nxt      = p_r;
    a_nxt      = a_r;
    root_nxt   = root_r;
    sat_nxt    = sat_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    case (state_r)
      blop_pkg::S_IDLE: begin
        if (accept) begin
          price_nxt  = in_data.spot_price;
          strike_nxt = in_data.strike;
          call_nxt   = in_data.is_call;
          p_nxt      = p_clamp;
          n_nxt      = n_clamp;
          sat_nxt    = 1'b0;
          cnt_nxt    = '0;
          idx_nxt    = '0;
        end
      end
      blop_pkg::S_UP_W: begin
        if (mul_rsp.done) begin
          price_nxt = mul_rsp.value;
          sat_nxt   = sat_r | mul_rsp.sat;
          cnt_nxt   = cnt_r + NW'(1);
        end
      end
      blop_pkg::S_PAY: begin
        if (idx_r == n_r) begin
          j_nxt = n_r;
          i_nxt = '0;
        end
      end
      blop_pkg::S_DN1_W: begin
        if (mul_rsp.done) begin
          price_nxt = mul_rsp.value;
          sat_nxt   = sat_r | mul_rsp.sat;
        end
      end
      blop_pkg::S_DN2_W: begin
        if (mul_rsp.done) begin
          price_nxt = mul_rsp.value;
          sat_nxt   = sat_r | mul_rsp.sat;
          idx_nxt   = idx_r + NW'(1);
        end
      end
      blop_pkg::S_RD0: begin
        a_nxt = ram_rdata;
      end
      blop_pkg::S_MIX: begin
        // Keep the old V[i+1]; it is the next update's V[i].
        a_nxt = ram_rdata;
      end
      blop_pkg::S_MIX_W: begin
        if (mul_rsp.done) sat_nxt = sat_r | mul_rsp.sat;
      end
      blop_pkg::S_DISC_W: begin
        if (mul_rsp.done) begin
          root_nxt = mul_rsp.value;
          sat_nxt  = sat_r | mul_rsp.sat;
          if (last_in_level) begin
            j_nxt = j_r - NW'(1);
            i_nxt = '0;
          end else begin
            i_nxt = i_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a word leaves when taken, a new one loads on handover.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (fin_go) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.option_price = root_r;
      out_data_nxt.saturated    = sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blop_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    price_r    <= price_nxt;
    strike_r   <= strike_nxt;
    call_r     <= call_nxt;
    p_r        <= p_nxt;
    a_r        <= a_nxt;
    root_r     <= root_nxt;
    sat_r      <= sat_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  blop_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  blop_ram #(
    .WIDTH (32),
    .DEPTH (MAX_STEPS + 1)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An accepted word always starts the up-move phase on the next cycle.
  `BLOP_ASSERT_NXT(a_accept_starts, clk, rst_n, accept, state_r == blop_pkg::S_UP)
  // A fold update only ever runs inside the current level.
  `BLOP_ASSERT_IMP(a_fold_index, clk, rst_n, state_r == blop_pkg::S_MIX, i_r < j_r)
  // The multiplier only completes while the sequencer is waiting for it.
  `BLOP_ASSERT_IMP(a_mul_done_waits, clk, rst_n, mul_rsp.done, mul_wait)

endmodule

/* rtl/core/blop_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module blop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/blop_mul.sv */
// Shared two-stage multiply, round and saturate unit of the lattice pricer.
module blop_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  blop_pkg::mul_req_t  req,
  output blop_pkg::mul_rsp_t  rsp
);

  logic                v1_r;
  logic [65:0]         prod_r;
  blop_pkg::mul_op_t   op_r;
  logic [31:0]         c_r;
  logic                done_r;
  logic [31:0]         value_r;
  logic                sat_r;

  logic signed [65:0]  prod_nxt;
  logic [65:0]         base;
  logic [65:0]         rnd;
  logic [65:0]         sum;
  logic [35:0]         shifted;
  logic                sat_nxt;
  logic [31:0]         value_nxt;

  // Operand a may be a signed difference; b is always non-negative.
  assign prod_nxt = $signed(req.a) * $signed({1'b0, req.b});

  // The blend term adds c * 2^31; every final sum is non-negative.
  always_comb begin
    base = '0;
    rnd  = 66'd1 << 30;
    case (op_r)
      blop_pkg::MUL_Q30: begin
        rnd = 66'd1 << 29;
      end
      blop_pkg::MUL_Q31: begin
        rnd = 66'd1 << 30;
      end
      blop_pkg::MUL_MIX: begin
        base = {3'b000, c_r, 31'b0};
      end
      default: begin
        base = '0;
      end
    endcase
  end

  assign sum       = prod_r + base + rnd;
  assign shifted   = (op_r == blop_pkg::MUL_Q30) ? sum[65:30] : {1'b0, sum[65:31]};
  assign sat_nxt   = |shifted[35:32];
  assign value_nxt = sat_nxt ? 32'hFFFF_FFFF : shifted[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.issue;
      done_r <= v1_r;
    end
    if (req.issue) begin
      prod_r <= prod_nxt;
      op_r   <= req.op;
      c_r    <= req.c;
    end
    if (v1_r) begin
      value_r <= value_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;
  assign rsp.sat   = sat_r;

endmodule
